FILE: rtl/core/e2c_pkg.sv
`default_nettype none

package e2c_pkg;

    // Input transaction: one cube face texel
    typedef struct packed {
        logic [2:0]  face;
        logic [11:0] col;
        logic [11:0] row;
    } t_in;

    // Output transaction: one source image address
    typedef struct packed {
        logic [12:0] src_col;
        logic [11:0] src_row;
        logic [24:0] src_pixel;
    } t_out;

    // Control travelling alongside the data in every cell
    typedef struct packed {
        logic       vld;
        logic [2:0] face;
    } t_tag;

    // Configuration register indexes
    localparam logic [1:0] CFG_FACE_SIZE  = 2'd0;
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd2;

    // Face codes
    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    // Angles as 32-bit fractions of a turn
    localparam logic [31:0] ANG_ZERO    = 32'h0000_0000;
    localparam logic [31:0] ANG_QUARTER = 32'h4000_0000;
    localparam logic [31:0] ANG_HALF    = 32'h8000_0000;
    localparam logic [31:0] ANG_3QUART  = 32'hC000_0000;

    // Reciprocal of the CORDIC gain, scaled by 2^32
    localparam logic [31:0] GAIN_INV = 32'd2608131496;

    localparam logic [13:0] MAX_SRC_W = 14'd8192;
    localparam logic [12:0] MAX_SRC_H = 13'd4096;

    // atan(2^-i) as a turn fraction, rounded to nearest
    function automatic logic [31:0] e2c_atan(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/equirect_to_cubemap_address_unit.sv
// Cubemap texel to equirectangular source address generator.
// Input channel (i_valid / o_stall / i_data): one transaction per cube face texel,
// carrying face code, column and row. Output channel (o_valid / i_stall / o_data):
// one transaction per input, carrying source column, row and linear pixel index.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write face size, source width
// and source height; only write while no transaction is in flight.
// Throughput: one transaction per clock, sustained while the receiver does not stall.
// Path to o_valid: bit-per-cell restoring divider, face vector register, phi
// prep and CORDIC vectoring chain, magnitude register, theta prep and chain (one
// step per cell in both chains), column/row register, output register.
// Every stage moves together; when a result sits in the output register and the
// receiver stalls, the whole chain holds and o_stall is raised. A result leaving
// in the same cycle makes room for a new transaction on the input side.
// Reset: synchronous, active low; clears all valid flags and loads face size 256,
// width 1024, height 512. No clearing pass is needed.
`default_nettype none

module equirect_to_cubemap_address_unit #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  e2c_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output e2c_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [13:0]   i_cfg_data
);
    import e2c_pkg::*;

    localparam int NW = 13 + FRAC_BITS;   // numerator: (2*idx+1) << FRAC_BITS
    localparam int QW = FRAC_BITS + 2;    // Q2.FRAC_BITS coordinate
    localparam int CW = FRAC_BITS + 3;    // direction component, holds +2.0
    localparam int DW = FRAC_BITS + 6;    // CORDIC datapath with growth headroom
    localparam int CS = CORDIC_STEPS;
    localparam int PW = DW - 1 + 32;      // magnitude product

    localparam logic signed [NW+1:0] ONE_W = (NW+2)'(2**FRAC_BITS);
    localparam logic signed [NW+1:0] LIM_W = (NW+2)'(2**(FRAC_BITS+1));
    localparam logic signed [CW-1:0] ONE_C = CW'(2**FRAC_BITS);

    // ---------------- configuration ----------------
    logic [12:0] r_face_size;
    logic [13:0] r_src_width;
    logic [12:0] r_src_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size  <= 13'd256;
            r_src_width  <= 14'd1024;
            r_src_height <= 13'd512;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FACE_SIZE:  r_face_size  <= i_cfg_data[12:0];
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic [12:0] fs_eff;
    logic [13:0] w_eff;
    logic [12:0] h_eff;
    logic [12:0] w_m1;
    logic [11:0] h_m1;

    always_comb begin
        fs_eff = (r_face_size == '0) ? 13'd1 : r_face_size;
        if (r_src_width == '0)           w_eff = 14'd1;
        else if (r_src_width > MAX_SRC_W) w_eff = MAX_SRC_W;
        else                              w_eff = r_src_width;
        if (r_src_height == '0)            h_eff = 13'd1;
        else if (r_src_height > MAX_SRC_H) h_eff = MAX_SRC_H;
        else                               h_eff = r_src_height;
        w_m1 = 13'(w_eff - 14'd1);
        h_m1 = 12'(h_eff - 13'd1);
    end

    // ---------------- flow control ----------------
    logic en;
    logic r_out_vld;

    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_out_vld;

    // ---------------- divider chain: u, v numerators over face size ----------------
    t_tag               d_tag  [NW+1];
    logic [1:0][NW-1:0] d_num  [NW+1];
    logic [1:0][12:0]   d_rem  [NW+1];
    logic [1:0][NW-1:0] d_quot [NW+1];

    assign d_tag[0]     = '{vld: i_valid, face: i_data.face};
    assign d_num[0][0]  = {i_data.col, 1'b1, {FRAC_BITS{1'b0}}};
    assign d_num[0][1]  = {i_data.row, 1'b1, {FRAC_BITS{1'b0}}};
    assign d_rem[0]     = '0;
    assign d_quot[0]    = '0;

    for (genvar g = 0; g < NW; g++) begin : g_div
        e2c_div_cell #(.NW(NW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_tag  (d_tag[g]),
            .i_div  (fs_eff),
            .i_num  (d_num[g]),
            .i_rem  (d_rem[g]),
            .i_quot (d_quot[g]),
            .o_tag  (d_tag[g+1]),
            .o_num  (d_num[g+1]),
            .o_rem  (d_rem[g+1]),
            .o_quot (d_quot[g+1])
        );
    end

    // ---------------- coordinates and face vector ----------------
    function automatic logic signed [QW-1:0] f_sat(input logic signed [NW+1:0] v);
        if (v < -LIM_W)          return QW'(-LIM_W);
        else if (v > LIM_W - 1)  return QW'(LIM_W - 1);
        else                     return QW'(v);
    endfunction

    logic signed [NW+1:0] t_col;
    logic signed [NW+1:0] t_row;
    logic signed [QW-1:0] u_q;
    logic signed [QW-1:0] tr_q;
    logic signed [QW-1:0] v_q;
    logic signed [CW-1:0] u_c;
    logic signed [CW-1:0] v_c;
    logic signed [CW-1:0] n_dx;
    logic signed [CW-1:0] n_dy;
    logic signed [CW-1:0] n_dz;

    always_comb begin
        t_col = $signed({2'b00, d_quot[NW][0]}) - ONE_W;
        t_row = $signed({2'b00, d_quot[NW][1]}) - ONE_W;
        u_q   = f_sat(t_col);
        tr_q  = f_sat(t_row);
        v_q   = f_sat(-$signed({{(NW+2-QW){tr_q[QW-1]}}, tr_q}));
        u_c   = $signed({u_q[QW-1], u_q});
        v_c   = $signed({v_q[QW-1], v_q});
        n_dx  = '0;
        n_dy  = '0;
        n_dz  = '0;
        case (d_tag[NW].face)
            FACE_PX: begin n_dx = ONE_C;  n_dy = -v_c;   n_dz = -u_c;   end
            FACE_NX: begin n_dx = -ONE_C; n_dy = -v_c;   n_dz = u_c;    end
            FACE_PY: begin n_dx = u_c;    n_dy = -ONE_C; n_dz = v_c;    end
            FACE_NY: begin n_dx = u_c;    n_dy = ONE_C;  n_dz = -v_c;   end
            FACE_PZ: begin n_dx = u_c;    n_dy = -v_c;   n_dz = ONE_C;  end
            FACE_NZ: begin n_dx = -u_c;   n_dy = -v_c;   n_dz = -ONE_C; end
            default: ;
        endcase
    end

    t_tag                 r_c_tag;
    logic signed [CW-1:0] r_dx;
    logic signed [CW-1:0] r_dy;
    logic signed [CW-1:0] r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_tag.vld <= 1'b0;
        end else if (en) begin
            r_c_tag <= d_tag[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_dz <= n_dz;
        end
    end

    // ---------------- phi = atan2(z, x) ----------------
    t_tag                 c1_tag [CS+1];
    logic signed [DW-1:0] c1_x   [CS+1];
    logic signed [DW-1:0] c1_y   [CS+1];
    logic [31:0]          c1_a   [CS+1];
    logic                 c1_byp [CS+1];
    logic signed [CW-1:0] r_dy_line [CS+1];

    e2c_vec_prep #(.W(DW)) u_prep_phi (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_tag  (r_c_tag),
        .i_x    ($signed({{(DW-CW){r_dx[CW-1]}}, r_dx})),
        .i_y    ($signed({{(DW-CW){r_dz[CW-1]}}, r_dz})),
        .o_tag  (c1_tag[0]),
        .o_x    (c1_x[0]),
        .o_y    (c1_y[0]),
        .o_a    (c1_a[0]),
        .o_byp  (c1_byp[0])
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dy_line[0] <= r_dy;
            for (int k = 0; k < CS; k++) begin
                r_dy_line[k+1] <= r_dy_line[k];
            end
        end
    end

    for (genvar g = 0; g < CS; g++) begin : g_phi
        e2c_cordic_cell #(.W(DW), .STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_tag  (c1_tag[g]),
            .i_x    (c1_x[g]),
            .i_y    (c1_y[g]),
            .i_a    (c1_a[g]),
            .i_byp  (c1_byp[g]),
            .o_tag  (c1_tag[g+1]),
            .o_x    (c1_x[g+1]),
            .o_y    (c1_y[g+1]),
            .o_a    (c1_a[g+1]),
            .o_byp  (c1_byp[g+1])
        );
    end

    // ---------------- horizontal magnitude, gain removed ----------------
    logic [PW-1:0]        mag_prod;
    logic signed [DW-1:0] n_mag;

    assign mag_prod = c1_x[CS][DW-2:0] * GAIN_INV;
    assign n_mag    = c1_byp[CS] ? c1_x[CS] : $signed({1'b0, mag_prod[PW-1:32]});

    t_tag                 r_m_tag;
    logic signed [DW-1:0] r_m_r;
    logic signed [CW-1:0] r_m_dy;
    logic [15:0]          r_m_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tag.vld <= 1'b0;
        end else if (en) begin
            r_m_tag <= c1_tag[CS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_r   <= n_mag;
            r_m_dy  <= r_dy_line[CS];
            r_m_phi <= c1_a[CS][31:16];
        end
    end

    // ---------------- theta = atan2(r, y) ----------------
    t_tag                 c2_tag [CS+1];
    logic signed [DW-1:0] c2_x   [CS+1];
    logic signed [DW-1:0] c2_y   [CS+1];
    logic [31:0]          c2_a   [CS+1];
    logic                 c2_byp [CS+1];
    logic [15:0]          r_phi_line [CS+1];

    e2c_vec_prep #(.W(DW)) u_prep_theta (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_tag  (r_m_tag),
        .i_x    ($signed({{(DW-CW){r_m_dy[CW-1]}}, r_m_dy})),
        .i_y    (r_m_r),
        .o_tag  (c2_tag[0]),
        .o_x    (c2_x[0]),
        .o_y    (c2_y[0]),
        .o_a    (c2_a[0]),
        .o_byp  (c2_byp[0])
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_phi_line[0] <= r_m_phi;
            for (int k = 0; k < CS; k++) begin
                r_phi_line[k+1] <= r_phi_line[k];
            end
        end
    end

    for (genvar g = 0; g < CS; g++) begin : g_theta
        e2c_cordic_cell #(.W(DW), .STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_tag  (c2_tag[g]),
            .i_x    (c2_x[g]),
            .i_y    (c2_y[g]),
            .i_a    (c2_a[g]),
            .i_byp  (c2_byp[g]),
            .o_tag  (c2_tag[g+1]),
            .o_x    (c2_x[g+1]),
            .o_y    (c2_y[g+1]),
            .o_a    (c2_a[g+1]),
            .o_byp  (c2_byp[g+1])
        );
    end

    // ---------------- angle to source column / row ----------------
    logic        bad_face;
    logic [15:0] phi16;
    logic [15:0] theta16;
    logic [28:0] col_prod;
    logic [27:0] row_prod;

    always_comb begin
        bad_face = (c2_tag[CS].face > FACE_NZ);
        phi16    = bad_face ? 16'd0 : r_phi_line[CS];
        // theta rounding past a pole folds back onto the pole
        if (bad_face)                      theta16 = 16'h4000;
        else if (c2_a[CS] > ANG_3QUART)    theta16 = 16'h0000;
        else if (c2_a[CS] > ANG_HALF)      theta16 = 16'h8000;
        else                               theta16 = c2_a[CS][31:16];
        col_prod = phi16 * w_m1;
        row_prod = theta16 * h_m1;
    end

    logic        r_s_vld;
    logic [12:0] r_s_col;
    logic [11:0] r_s_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (en) begin
            r_s_vld <= c2_tag[CS].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_col <= col_prod[28:16];
            r_s_row <= row_prod[26:15];
        end
    end

    // ---------------- linear index and output register ----------------
    logic [26:0] pix_sum;
    t_out        r_out;

    assign pix_sum = 27'(r_s_row) * 27'(w_eff) + 27'(r_s_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.src_col   <= r_s_col;
            r_out.src_row   <= r_s_row;
            r_out.src_pixel <= pix_sum[24:0];
        end
    end

    assign o_data = r_out;

    // ---------------- assertions ----------------
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while output held");

    a_accept_enters_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> d_tag[1].vld)
        else $error("accepted transaction missing from first cell");

endmodule

`default_nettype wire

FILE: rtl/core/e2c_div_cell.sv
`default_nettype none

// One quotient bit of a restoring divider, two lanes (column and row)
module e2c_div_cell #(
    parameter int NW = 29
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  e2c_pkg::t_tag         i_tag,
    input  logic [12:0]           i_div,
    input  logic [1:0][NW-1:0]    i_num,
    input  logic [1:0][12:0]      i_rem,
    input  logic [1:0][NW-1:0]    i_quot,
    output e2c_pkg::t_tag         o_tag,
    output logic [1:0][NW-1:0]    o_num,
    output logic [1:0][12:0]      o_rem,
    output logic [1:0][NW-1:0]    o_quot
);
    import e2c_pkg::*;

    logic [1:0][13:0]   rem_s;
    logic [1:0]         ge;
    logic [1:0][NW-1:0] n_num;
    logic [1:0][12:0]   n_rem;
    logic [1:0][NW-1:0] n_quot;

    t_tag               r_tag;
    logic [1:0][NW-1:0] r_num;
    logic [1:0][12:0]   r_rem;
    logic [1:0][NW-1:0] r_quot;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            rem_s[k]  = {i_rem[k], i_num[k][NW-1]};
            ge[k]     = (rem_s[k] >= {1'b0, i_div});
            n_rem[k]  = ge[k] ? 13'(rem_s[k] - {1'b0, i_div}) : rem_s[k][12:0];
            n_quot[k] = {i_quot[k][NW-2:0], ge[k]};
            n_num[k]  = {i_num[k][NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_tag  = r_tag;
    assign o_num  = r_num;
    assign o_rem  = r_rem;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

FILE: rtl/core/e2c_vec_prep.sv
`default_nettype none

// Axis cases and half-plane fold ahead of a CORDIC vectoring chain
module e2c_vec_prep #(
    parameter int W = 22
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  e2c_pkg::t_tag       i_tag,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    output e2c_pkg::t_tag       o_tag,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic [31:0]         o_a,
    output logic                o_byp
);
    import e2c_pkg::*;

    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    logic [31:0]         n_a;
    logic                n_byp;

    t_tag                r_tag;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic [31:0]         r_a;
    logic                r_byp;

    always_comb begin
        n_x   = i_x;
        n_y   = i_y;
        n_a   = ANG_ZERO;
        n_byp = 1'b0;
        if (i_tag.face > FACE_NZ) begin
            n_x   = '0;
            n_y   = '0;
            n_byp = 1'b1;
        end else if (i_y == '0) begin
            n_byp = 1'b1;
            if (i_x < 0) begin
                n_a = ANG_HALF;
                n_x = -i_x;
            end
        end else if (i_x == '0) begin
            n_byp = 1'b1;
            n_a   = (i_y > 0) ? ANG_QUARTER : ANG_3QUART;
            n_x   = (i_y < 0) ? -i_y : i_y;
        end else if (i_x < 0) begin
            n_x = -i_x;
            n_y = -i_y;
            n_a = ANG_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_a   <= n_a;
            r_byp <= n_byp;
        end
    end

    assign o_tag = r_tag;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_a   = r_a;
    assign o_byp = r_byp;

endmodule

`default_nettype wire

FILE: rtl/core/e2c_cordic_cell.sv
`default_nettype none

// One CORDIC vectoring micro-rotation
module e2c_cordic_cell #(
    parameter int W    = 22,
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  e2c_pkg::t_tag       i_tag,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic [31:0]         i_a,
    input  logic                i_byp,
    output e2c_pkg::t_tag       o_tag,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic [31:0]         o_a,
    output logic                o_byp
);
    import e2c_pkg::*;

    localparam logic [31:0] ATAN_K = e2c_atan(STEP);

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    logic [31:0]         n_a;

    t_tag                r_tag;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic [31:0]         r_a;
    logic                r_byp;

    always_comb begin
        xs  = i_x >>> STEP;
        ys  = i_y >>> STEP;
        n_x = i_x;
        n_y = i_y;
        n_a = i_a;
        if (!i_byp) begin
            if (i_y > 0) begin
                n_x = i_x + ys;
                n_y = i_y - xs;
                n_a = i_a + ATAN_K;
            end else begin
                n_x = i_x - ys;
                n_y = i_y + xs;
                n_a = i_a - ATAN_K;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_a   <= n_a;
            r_byp <= i_byp;
        end
    end

    assign o_tag = r_tag;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_a   = r_a;
    assign o_byp = r_byp;

endmodule

`default_nettype wire
